// File: rtl/trg_pkg.sv
package trg_pkg;

	// Unit vector components are signed Q.30 carried in UW bits.
	localparam int UW = 32;
	// Normalized magnitudes before the square-sum.
	localparam int MW = 30;
	// CORDIC datapath widths.
	localparam int CW = 34;
	localparam int ZW = 33;
	localparam int CORDIC_STEPS = 16;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_X = 3'd0,
		REG_SCALE_Y = 3'd1,
		REG_LENS_RADIUS = 3'd2,
		REG_FOCAL_DIST = 3'd3,
		REG_ROW0 = 3'd4,
		REG_ROW1 = 3'd5,
		REG_ROW2 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [15:0] rand_radius;
		logic [15:0] rand_angle;
	} req_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} rsp_t;

	// atan(2^-k) in Q.30
	function automatic logic [31:0] atan_q30(input int unsigned k);
		logic [31:0] a;
		case (k)
			0: a = 32'd843314856;
			1: a = 32'd497837829;
			2: a = 32'd263043837;
			3: a = 32'd133525158;
			4: a = 32'd67021687;
			5: a = 32'd33543515;
			6: a = 32'd16775850;
			7: a = 32'd8388437;
			8: a = 32'd4194282;
			9: a = 32'd2097149;
			10: a = 32'd1048575;
			11: a = 32'd524287;
			12: a = 32'd262143;
			13: a = 32'd131071;
			14: a = 32'd65535;
			15: a = 32'd32767;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/trg_stream_if.sv
interface trg_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/trg_isqrt.sv
module trg_isqrt #(
	parameter int RW = 32,
	parameter type SIDE_T = logic
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [RW-1:0] in_rad,
	input SIDE_T in_side,
	output logic out_valid,
	output logic [RW/2-1:0] out_root,
	output SIDE_T out_side
);
	localparam int N = RW / 2;

	// one result bit per stage
	logic [RW-1:0] v_s [N];
	logic [RW-1:0] r_s [N];
	SIDE_T sd_s [N];
	logic [N-1:0] vld_s;
	logic [RW-1:0] v_n [N];
	logic [RW-1:0] r_n [N];

	always_comb begin
		logic [RW-1:0] vi, ri;
		logic [RW:0] bb, t;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				vi = in_rad;
				ri = '0;
			end else begin
				vi = v_s[k-1];
				ri = r_s[k-1];
			end
			bb = (RW+1)'(1) << (RW - 2 - 2*k);
			t = {1'b0, ri} + bb;
			if ({1'b0, vi} >= t) begin
				v_n[k] = vi - t[RW-1:0];
				r_n[k] = (ri >> 1) + bb[RW-1:0];
			end else begin
				v_n[k] = vi;
				r_n[k] = ri >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				v_s[k] <= v_n[k];
				r_s[k] <= r_n[k];
				sd_s[k] <= (k == 0) ? in_side : sd_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root = r_s[N-1][N-1:0];
	assign out_side = sd_s[N-1];
endmodule

// File: rtl/trg_cordic.sv
module trg_cordic #(
	parameter type SIDE_T = logic
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [15:0] in_turn,
	input SIDE_T in_side,
	output logic out_valid,
	output logic signed [trg_pkg::CW-1:0] out_cos,
	output logic signed [trg_pkg::CW-1:0] out_sin,
	output SIDE_T out_side
);
	import trg_pkg::*;

	localparam int NS = CORDIC_STEPS;

	logic [45:0] zp_c;
	logic signed [ZW-1:0] z_s0;
	logic [1:0] quad_s0;
	SIDE_T sd_s0;

	logic signed [CW-1:0] x_s [NS];
	logic signed [CW-1:0] y_s [NS];
	logic signed [ZW-1:0] z_s [NS];
	logic [1:0] qd_s [NS];
	SIDE_T sd_s [NS];
	logic signed [CW-1:0] x_n [NS];
	logic signed [CW-1:0] y_n [NS];
	logic signed [ZW-1:0] z_n [NS];

	logic [NS+1:0] vld_s;
	logic signed [CW-1:0] cos_q, sin_q;
	SIDE_T sd_q;

	// quarter-turn angle to Q.30 radians
	assign zp_c = 46'(in_turn[13:0]) * 46'(PI_Q30);

	always_comb begin
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi, at;
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				xi = CW'(CORDIC_GAIN_Q30);
				yi = '0;
				zi = z_s0;
			end else begin
				xi = x_s[k-1];
				yi = y_s[k-1];
				zi = z_s[k-1];
			end
			at = $signed({1'b0, atan_q30(k)});
			if (zi >= 0) begin
				x_n[k] = xi - (yi >>> k);
				y_n[k] = yi + (xi >>> k);
				z_n[k] = zi - at;
			end else begin
				x_n[k] = xi + (yi >>> k);
				y_n[k] = yi - (xi >>> k);
				z_n[k] = zi + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s0 <= ZW'(zp_c[45:15]);
			quad_s0 <= in_turn[15:14];
			sd_s0 <= in_side;
			for (int k = 0; k < NS; k++) begin
				x_s[k] <= x_n[k];
				y_s[k] <= y_n[k];
				z_s[k] <= z_n[k];
				qd_s[k] <= (k == 0) ? quad_s0 : qd_s[(k == 0) ? 0 : k-1];
				sd_s[k] <= (k == 0) ? sd_s0 : sd_s[(k == 0) ? 0 : k-1];
			end
			case (qd_s[NS-1])
				2'd0: begin
					cos_q <= x_s[NS-1];
					sin_q <= y_s[NS-1];
				end
				2'd1: begin
					cos_q <= -y_s[NS-1];
					sin_q <= x_s[NS-1];
				end
				2'd2: begin
					cos_q <= -x_s[NS-1];
					sin_q <= -y_s[NS-1];
				end
				default: begin
					cos_q <= y_s[NS-1];
					sin_q <= -x_s[NS-1];
				end
			endcase
			sd_q <= sd_s[NS-1];
		end
	end

	assign out_valid = vld_s[NS+1];
	assign out_cos = cos_q;
	assign out_sin = sin_q;
	assign out_side = sd_q;
endmodule

// File: rtl/trg_unitize.sv
module trg_unitize #(
	parameter int W = 41,
	parameter type SIDE_T = logic
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [2:0][W-1:0] in_vec,
	input SIDE_T in_side,
	output logic out_valid,
	output logic out_nz,
	output logic [2:0][trg_pkg::UW-1:0] out_vec,
	output SIDE_T out_side
);
	import trg_pkg::*;

	localparam int BLW = $clog2(W + 1);
	localparam int SW = 2 * MW + 2;
	localparam int LW = SW / 2;

	typedef struct packed {
		SIDE_T side;
		logic [2:0] neg;
	} tag_t;

	typedef struct packed {
		SIDE_T side;
		logic [2:0] neg;
		logic nz;
		logic [2:0][MW-1:0] mag;
	} norm_t;

	typedef struct packed {
		norm_t nt;
		logic [LW-1:0] len;
		logic [2:0][LW-1:0] rem;
		logic [2:0][LW-1:0] quo;
	} div_t;

	// front: magnitude, max, bit length, align, square, sum
	logic [5:0] vld_s;
	logic [2:0][W-1:0] abs_c, mag_s1, mag_s2, mag_s3;
	logic [2:0] neg_c;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [W-1:0] max_c, max_s2;
	logic [BLW-1:0] bl_c, bl_s3;
	logic [2:0][MW-1:0] m30_c, m30_s4, m30_s5;
	logic nz_s4, nz_s5;
	logic [2:0][2*MW-1:0] sq_c, sq_s5;
	logic [SW-1:0] sum_s6;
	norm_t nt_s6;

	logic sq_vld;
	logic [LW-1:0] sq_root;
	norm_t sq_side;

	div_t dv_n [LW];
	div_t dv_s [LW];
	logic [LW-1:0] dv_vld_s;

	logic vld_q, nz_q;
	logic [2:0][UW-1:0] vec_q;
	SIDE_T side_q;

	always_comb begin
		logic [W-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = in_vec[i][W-1];
			abs_c[i] = neg_c[i] ? (~in_vec[i] + W'(1)) : in_vec[i];
		end
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) max_c = mag_s1[1];
		if (mag_s1[2] > max_c) max_c = mag_s1[2];
		bl_c = '0;
		for (int j = 0; j < W; j++) begin
			if (max_s2[j]) bl_c = BLW'(j + 1);
		end
		for (int i = 0; i < 3; i++) begin
			if (bl_s3 > BLW'(MW)) sh = mag_s3[i] >> (bl_s3 - BLW'(MW));
			else sh = mag_s3[i] << (BLW'(MW) - bl_s3);
			m30_c[i] = sh[MW-1:0];
			sq_c[i] = (2*MW)'(m30_s4[i]) * (2*MW)'(m30_s4[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.side <= in_side;
			tag_s1.neg <= neg_c;
			mag_s1 <= abs_c;
			tag_s2 <= tag_s1;
			mag_s2 <= mag_s1;
			max_s2 <= max_c;
			tag_s3 <= tag_s2;
			mag_s3 <= mag_s2;
			bl_s3 <= bl_c;
			tag_s4 <= tag_s3;
			m30_s4 <= m30_c;
			nz_s4 <= (bl_s3 != '0);
			tag_s5 <= tag_s4;
			m30_s5 <= m30_s4;
			nz_s5 <= nz_s4;
			sq_s5 <= sq_c;
			sum_s6 <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
			nt_s6.side <= tag_s5.side;
			nt_s6.neg <= tag_s5.neg;
			nt_s6.nz <= nz_s5;
			nt_s6.mag <= m30_s5;
		end
	end

	trg_isqrt #(
		.RW(SW),
		.SIDE_T(norm_t)
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s[5]),
		.in_rad(sum_s6),
		.in_side(nt_s6),
		.out_valid(sq_vld),
		.out_root(sq_root),
		.out_side(sq_side)
	);

	// restoring divide (mag << 30) / len, one quotient bit per stage
	always_comb begin
		div_t cur;
		logic [2:0] bin;
		logic [LW:0] trial;
		logic ge;
		for (int j = 0; j < LW; j++) begin
			if (j == 0) begin
				cur.nt = sq_side;
				cur.len = sq_root;
				for (int i = 0; i < 3; i++) begin
					cur.rem[i] = LW'(sq_side.mag[i] >> 1);
					cur.quo[i] = '0;
					bin[i] = sq_side.mag[i][0];
				end
			end else begin
				cur = dv_s[j-1];
				bin = '0;
			end
			dv_n[j] = cur;
			for (int i = 0; i < 3; i++) begin
				trial = {cur.rem[i], bin[i]};
				ge = (trial >= {1'b0, cur.len});
				dv_n[j].rem[i] = ge ? LW'(trial - {1'b0, cur.len}) : LW'(trial);
				dv_n[j].quo[i] = {cur.quo[i][LW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			dv_vld_s <= {dv_vld_s[LW-2:0], sq_vld};
			vld_q <= dv_vld_s[LW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < LW; j++) begin
				dv_s[j] <= dv_n[j];
			end
			for (int i = 0; i < 3; i++) begin
				if (!dv_s[LW-1].nt.nz) vec_q[i] <= '0;
				else if (dv_s[LW-1].nt.neg[i]) vec_q[i] <= -UW'(dv_s[LW-1].quo[i]);
				else vec_q[i] <= UW'(dv_s[LW-1].quo[i]);
			end
			nz_q <= dv_s[LW-1].nt.nz;
			side_q <= dv_s[LW-1].nt.side;
		end
	end

	assign out_valid = vld_q;
	assign out_nz = nz_q;
	assign out_vec = vec_q;
	assign out_side = side_q;
endmodule

// File: rtl/thin_lens_ray_generator_core.sv
// Thin-lens camera ray generator, fully pipelined.
// 251 register stages from the request capture to the result register.
// Throughput: one request per cycle unless stalled; the three vector normalizations
// (31-stage square root plus 31-stage divide each) set the depth.
// A full output register stalls the whole pipe; nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits and loads the config defaults.
module thin_lens_ray_generator_core (
	input logic clk,
	input logic arst_n,
	trg_stream_if.sink req,
	trg_stream_if.source rsp,
	input logic cfg_we,
	input logic [trg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [trg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import trg_pkg::*;

	// lens offset, first normalize input, lens ray, world direction widths
	localparam int LXW = 36;
	localparam int V1W = 41;
	localparam int WW = 37;
	localparam int WDW = 50;
	localparam logic signed [66:0] HALF30_67 = 67'sd536870912;
	localparam logic signed [64:0] HALF30_65 = 65'sd536870912;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [15:0] ra;
	} rad_side_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [15:0] r;
	} cs_side_t;

	typedef struct packed {
		logic signed [LXW-1:0] lx;
		logic signed [LXW-1:0] ly;
	} u1_side_t;

	typedef struct packed {
		logic [2:0][UW-1:0] d;
		logic signed [LXW-1:0] lx;
		logic signed [LXW-1:0] ly;
	} u2_side_t;

	typedef struct packed {
		logic [2:0][31:0] org;
	} u3_side_t;

	// ---------------------------------------------------------------
	// Config regs; user keeps them static while requests are in flight (not enforced).
	// ---------------------------------------------------------------
	logic [23:0] scale_x_q, scale_y_q;
	logic [31:0] lens_q, focal_q;
	logic [63:0] row_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= 24'd65536;
			scale_y_q <= 24'd65536;
			lens_q <= '0;
			focal_q <= 32'd65536;
			row_q[0] <= 64'd4096;
			row_q[1] <= 64'd268435456;
			row_q[2] <= 64'd17592186044416;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_SCALE_X: scale_x_q <= cfg_wdata[23:0];
				REG_SCALE_Y: scale_y_q <= cfg_wdata[23:0];
				REG_LENS_RADIUS: lens_q <= cfg_wdata[31:0];
				REG_FOCAL_DIST: focal_q <= cfg_wdata[31:0];
				REG_ROW0: row_q[0] <= cfg_wdata;
				REG_ROW1: row_q[1] <= cfg_wdata;
				REG_ROW2: row_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Global stall: every stage advances when the output register is
	// free or being drained.
	// ---------------------------------------------------------------
	logic en;
	logic rsp_vld_q;

	assign en = !rsp_vld_q || rsp.ready;
	assign req.ready = en;

	// S1: request capture
	logic vld_s1;
	logic signed [15:0] px_s1, py_s1;
	logic [15:0] rr_s1, ra_s1;
	rad_side_t rad_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= req.data.pixel_x;
			py_s1 <= req.data.pixel_y;
			rr_s1 <= req.data.rand_radius;
			ra_s1 <= req.data.rand_angle;
		end
	end

	assign rad_side.px = px_s1;
	assign rad_side.py = py_s1;
	assign rad_side.ra = ra_s1;

	// Disk radius: sqrt of the uniform sample, Q0.16
	logic rad_vld;
	logic [15:0] rad_r;
	rad_side_t rad_out;

	trg_isqrt #(
		.RW(32),
		.SIDE_T(rad_side_t)
	) u_rad (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s1),
		.in_rad({rr_s1, 16'd0}),
		.in_side(rad_side),
		.out_valid(rad_vld),
		.out_root(rad_r),
		.out_side(rad_out)
	);

	// Disk angle: cos/sin by rotation CORDIC
	cs_side_t cs_in, cs_out;
	logic cs_vld;
	logic signed [CW-1:0] cos_c, sin_c;

	assign cs_in.px = rad_out.px;
	assign cs_in.py = rad_out.py;
	assign cs_in.r = rad_r;

	trg_cordic #(
		.SIDE_T(cs_side_t)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(rad_vld),
		.in_turn(rad_out.ra),
		.in_side(cs_in),
		.out_valid(cs_vld),
		.out_cos(cos_c),
		.out_sin(sin_c),
		.out_side(cs_out)
	);

	// S2: scaled radius R = round(lens * r / 2^16)
	// S3: R * cos, R * sin
	// S4: lens offset (rounded), image point times field-of-view scale
	logic vld_s2, vld_s3, vld_s4;
	logic [47:0] lr_c;
	logic [31:0] rr_s2;
	logic signed [CW-1:0] cos_s2, sin_s2;
	logic signed [15:0] px_s2, py_s2, px_s3, py_s3;
	logic signed [66:0] pc_s3, ps_s3;
	logic signed [LXW-1:0] lx_s4, ly_s4;
	logic signed [V1W-1:0] v0_s4, v1_s4;
	logic signed [66:0] lxr_c, lyr_c;
	u1_side_t u1_side;

	assign lr_c = 48'(lens_q) * 48'(cs_out.r);
	assign lxr_c = (pc_s3 + HALF30_67) >>> 30;
	assign lyr_c = (ps_s3 + HALF30_67) >>> 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= cs_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s2 <= 32'((lr_c + 48'd32768) >> 16);
			cos_s2 <= cos_c;
			sin_s2 <= sin_c;
			px_s2 <= cs_out.px;
			py_s2 <= cs_out.py;
			pc_s3 <= $signed({1'b0, rr_s2}) * cos_s2;
			ps_s3 <= $signed({1'b0, rr_s2}) * sin_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			// pinhole: a zero radius gives a zero lens offset
			lx_s4 <= (lens_q != '0) ? LXW'(lxr_c) : '0;
			ly_s4 <= (lens_q != '0) ? LXW'(lyr_c) : '0;
			v0_s4 <= px_s3 * $signed({1'b0, scale_x_q});
			v1_s4 <= py_s3 * $signed({1'b0, scale_y_q});
		end
	end

	assign u1_side.lx = lx_s4;
	assign u1_side.ly = ly_s4;

	// U1: camera-space direction d = unit(v0, v1, 2^31)
	logic u1_vld, u1_nz;
	logic [2:0][UW-1:0] d_c;
	u1_side_t u1_out;

	trg_unitize #(
		.W(V1W),
		.SIDE_T(u1_side_t)
	) u_norm_cam (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s4),
		.in_vec({V1W'(33'h0_8000_0000), v1_s4, v0_s4}),
		.in_side(u1_side),
		.out_valid(u1_vld),
		.out_nz(u1_nz),
		.out_vec(d_c),
		.out_side(u1_out)
	);

	// S5: d * focal distance
	// S6: focus point (rounded) minus lens offset
	logic vld_s5, vld_s6;
	logic signed [64:0] pd_s5 [3];
	logic [2:0][UW-1:0] d_s5, d_s6;
	logic signed [LXW-1:0] lx_s5, ly_s5, lx_s6, ly_s6;
	logic signed [64:0] pf_c [3];
	logic [2:0][WW-1:0] w_s6;
	u2_side_t u2_side;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pf_c[i] = (pd_s5[i] + HALF30_65) >>> 30;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= u1_vld;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pd_s5[i] <= $signed(d_c[i]) * $signed({1'b0, focal_q});
			end
			d_s5 <= d_c;
			lx_s5 <= u1_out.lx;
			ly_s5 <= u1_out.ly;
			w_s6[0] <= WW'(pf_c[0]) - WW'(lx_s5);
			w_s6[1] <= WW'(pf_c[1]) - WW'(ly_s5);
			w_s6[2] <= WW'(pf_c[2]);
			d_s6 <= d_s5;
			lx_s6 <= lx_s5;
			ly_s6 <= ly_s5;
		end
	end

	assign u2_side.d = d_s6;
	assign u2_side.lx = lx_s6;
	assign u2_side.ly = ly_s6;

	// U2: lens ray direction; a zero vector falls back to d
	logic u2_vld, u2_nz;
	logic [2:0][UW-1:0] u_c;
	u2_side_t u2_out;

	trg_unitize #(
		.W(WW),
		.SIDE_T(u2_side_t)
	) u_norm_lens (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s6),
		.in_vec(w_s6),
		.in_side(u2_side),
		.out_valid(u2_vld),
		.out_nz(u2_nz),
		.out_vec(u_c),
		.out_side(u2_out)
	);

	// S7: matrix products; S8: row sums; S9: origin round, translate, saturate
	logic vld_s7, vld_s8, vld_s9;
	logic [2:0][UW-1:0] uu_c;
	logic signed [47:0] pm_s7 [3][3];
	logic signed [51:0] po0_s7 [3];
	logic signed [51:0] po1_s7 [3];
	logic [2:0][WDW-1:0] wd_s8, wd_s9;
	logic signed [52:0] os_s8 [3];
	logic signed [53:0] oc_c [3];
	logic [2:0][31:0] org_s9;
	u3_side_t u3_side;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			uu_c[j] = u2_nz ? u_c[j] : u2_out.d[j];
		end
		for (int i = 0; i < 3; i++) begin
			oc_c[i] = ((54'(os_s8[i]) + 54'sd2048) >>> 12)
				+ (54'($signed(row_q[i][63:48])) <<< 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s7 <= u2_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pm_s7[i][j] <= $signed(row_q[i][16*j +: 16]) * $signed(uu_c[j]);
				end
				po0_s7[i] <= $signed(row_q[i][15:0]) * u2_out.lx;
				po1_s7[i] <= $signed(row_q[i][31:16]) * u2_out.ly;
				wd_s8[i] <= WDW'(pm_s7[i][0]) + WDW'(pm_s7[i][1]) + WDW'(pm_s7[i][2]);
				os_s8[i] <= 53'(po0_s7[i]) + 53'(po1_s7[i]);
				if (oc_c[i] > 54'sd2147483647) org_s9[i] <= 32'h7FFF_FFFF;
				else if (oc_c[i] < -54'sd2147483648) org_s9[i] <= 32'h8000_0000;
				else org_s9[i] <= oc_c[i][31:0];
			end
			wd_s9 <= wd_s8;
		end
	end

	assign u3_side.org = org_s9;

	// U3: world direction; zero vector gives zero
	logic u3_vld, u3_nz;
	logic [2:0][UW-1:0] dw_c;
	u3_side_t u3_out;

	trg_unitize #(
		.W(WDW),
		.SIDE_T(u3_side_t)
	) u_norm_world (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(vld_s9),
		.in_vec(wd_s9),
		.in_side(u3_side),
		.out_valid(u3_vld),
		.out_nz(u3_nz),
		.out_vec(dw_c),
		.out_side(u3_out)
	);

	// Output register: Q.30 direction rounded to Q2.14
	logic [2:0][15:0] dir_q;
	logic [2:0][31:0] org_q;
	logic [2:0][31:0] dwr_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dwr_c[i] = u3_nz ? 32'(($signed(dw_c[i]) + 32'sd32768) >>> 16) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_vld_q <= 1'b0;
		else if (en) rsp_vld_q <= u3_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= dwr_c[i][15:0];
			end
			org_q <= u3_out.org;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data.origin_x = org_q[0];
	assign rsp.data.origin_y = org_q[1];
	assign rsp.data.origin_z = org_q[2];
	assign rsp.data.dir_x = dir_q[0];
	assign rsp.data.dir_y = dir_q[1];
	assign rsp.data.dir_z = dir_q[2];
endmodule
